// ===== design/stick_to_servo_conditioner_macros.svh =====
// assertion macros shared by the stick to servo conditioner
`ifndef STICK_TO_SERVO_CONDITIONER_MACROS_SVH
`define STICK_TO_SERVO_CONDITIONER_MACROS_SVH

// same-cycle implication
`define STSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stsc same-cycle check failed");

// next-cycle implication
`define STSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stsc next-cycle check failed");

`endif

// ===== design/stsc_pkg.sv =====
// types, constants and codes of the stick to servo conditioner
package stsc_pkg;

   localparam int STICK_BITS    = 12;
   localparam int FRAC_BITS     = 8;
   localparam int FILT_BITS     = STICK_BITS + FRAC_BITS;
   localparam int DIFF_BITS     = FILT_BITS + 1;
   localparam int SUM_BITS      = FILT_BITS + 2;
   localparam int IN_STICK_BITS = 12;
   localparam int CFG_BITS      = 12;
   localparam int ALPHA_BITS    = 9;
   localparam int ALPHA_SHIFT   = 8;
   localparam int DEG_BITS      = 8;
   localparam int STEP_BITS     = 8;
   localparam int TIME_BITS     = 16;
   localparam int ESC_BITS      = 12;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int NUM_CH        = 4;
   localparam int CMP_BITS      = (STICK_BITS > CFG_BITS) ? STICK_BITS : CFG_BITS;

   localparam int MUL_A_BITS = DIFF_BITS;
   localparam int MUL_B_BITS = CFG_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int DIV_BITS   = STICK_BITS + CFG_BITS;
   localparam int QE_BITS    = DIV_BITS + 1 - STICK_BITS;
   localparam int REM_BITS   = DIV_BITS + 2;

   localparam logic [STICK_BITS-1:0] STICK_MAX = '1;
   localparam logic [FILT_BITS-1:0]  FILT_MAX  = {STICK_MAX, {FRAC_BITS{1'b0}}};
   localparam logic [FILT_BITS-1:0]  FILT_CENTER_RST = FILT_BITS'(2048) << FRAC_BITS;

   localparam logic [ALPHA_BITS-1:0] ALPHA_ONE     = ALPHA_BITS'(1) << ALPHA_SHIFT;
   localparam logic [DEG_BITS-1:0]   SERVO_MAX_DEG = DEG_BITS'(180);
   localparam logic [DEG_BITS-1:0]   SERVO_MID_DEG = DEG_BITS'(90);
   localparam logic [TIME_BITS-1:0]  TIME_SAT      = '1;

   localparam logic KIND_PACKET = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   typedef logic [1:0] chan_type;
   localparam chan_type CH_LX    = 2'd0;
   localparam chan_type CH_LY    = 2'd1;
   localparam chan_type CH_RX    = 2'd2;
   localparam chan_type CH_RY    = 2'd3;
   localparam chan_type CH_FIRST = CH_LX;
   localparam chan_type CH_LAST  = CH_RY;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   localparam csr_idx_type CSR_STICK_CENTER = 3'd0;
   localparam csr_idx_type CSR_DEADBAND     = 3'd1;
   localparam csr_idx_type CSR_ALPHA        = 3'd2;
   localparam csr_idx_type CSR_THR_MIN      = 3'd3;
   localparam csr_idx_type CSR_THR_MAX      = 3'd4;
   localparam csr_idx_type CSR_STEP_MIN     = 3'd5;
   localparam csr_idx_type CSR_TIMEOUT      = 3'd6;

   typedef struct packed {
      logic [CFG_BITS-1:0]   center;
      logic [CFG_BITS-1:0]   deadband;
      logic [ALPHA_BITS-1:0] alpha;
      logic [CFG_BITS-1:0]   thr_min;
      logic [CFG_BITS-1:0]   thr_max;
      logic [STEP_BITS-1:0]  step_min;
      logic [TIME_BITS-1:0]  timeout;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FMUL,
      ST_FADD,
      ST_MMUL,
      ST_MDIV,
      ST_MCOR,
      ST_WB
   } state_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      state_type  state;
      chan_type   chan;
      alu_op_type op;
   } ctl_type;

endpackage

// ===== design/stsc_csr.sv =====
// configuration registers of the stick to servo conditioner
module stsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  stsc_pkg::csr_idx_type               csr_index,
   input  logic [stsc_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output stsc_pkg::cfg_type                   cfg
);

   stsc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            stsc_pkg::CSR_STICK_CENTER: cfg_in.center   = stsc_pkg::CFG_BITS'(csr_wr_data);
            stsc_pkg::CSR_DEADBAND:     cfg_in.deadband = stsc_pkg::CFG_BITS'(csr_wr_data);
            stsc_pkg::CSR_ALPHA:        cfg_in.alpha    = stsc_pkg::ALPHA_BITS'(csr_wr_data);
            stsc_pkg::CSR_THR_MIN:      cfg_in.thr_min  = stsc_pkg::CFG_BITS'(csr_wr_data);
            stsc_pkg::CSR_THR_MAX:      cfg_in.thr_max  = stsc_pkg::CFG_BITS'(csr_wr_data);
            stsc_pkg::CSR_STEP_MIN:     cfg_in.step_min = stsc_pkg::STEP_BITS'(csr_wr_data);
            stsc_pkg::CSR_TIMEOUT:      cfg_in.timeout  = stsc_pkg::TIME_BITS'(csr_wr_data);
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center   <= stsc_pkg::CFG_BITS'(2048);
         cfg_ff.deadband <= stsc_pkg::CFG_BITS'(45);
         cfg_ff.alpha    <= stsc_pkg::ALPHA_BITS'(90);
         cfg_ff.thr_min  <= stsc_pkg::CFG_BITS'(1100);
         cfg_ff.thr_max  <= stsc_pkg::CFG_BITS'(1940);
         cfg_ff.step_min <= stsc_pkg::STEP_BITS'(2);
         cfg_ff.timeout  <= stsc_pkg::TIME_BITS'(300);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/stsc_alu.sv =====
// shared multiplier and divide-by-stick-max unit
module stsc_alu (
   input  logic                                       clock,
   input  stsc_pkg::alu_op_type                       op,
   input  logic signed [stsc_pkg::MUL_A_BITS-1:0]     mul_a,
   input  logic signed [stsc_pkg::MUL_B_BITS-1:0]     mul_b,
   output logic signed [stsc_pkg::PROD_BITS-1:0]      prod,
   output logic        [stsc_pkg::CFG_BITS-1:0]       quo
);

   logic signed [stsc_pkg::PROD_BITS-1:0] prod_ff, prod_in;
   logic [stsc_pkg::QE_BITS-1:0]          qe_ff, qe_in;
   logic [stsc_pkg::DIV_BITS-1:0]         num;
   logic [stsc_pkg::DIV_BITS:0]           num_sum;
   logic [stsc_pkg::REM_BITS-1:0]         rem;

   assign num     = prod_ff[stsc_pkg::DIV_BITS-1:0];
   // estimate of num / (2^s - 1), low by at most one
   assign num_sum = {1'b0, num} + (stsc_pkg::DIV_BITS + 1)'(num >> stsc_pkg::STICK_BITS);

   always_comb begin
      prod_in = prod_ff;
      qe_in   = qe_ff;
      case (op)
         stsc_pkg::ALU_MUL: prod_in = mul_a * mul_b;
         stsc_pkg::ALU_DIV: qe_in   = num_sum[stsc_pkg::DIV_BITS:stsc_pkg::STICK_BITS];
         default: begin
            prod_in = prod_ff;
            qe_in   = qe_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      qe_ff   <= qe_in;
   end

   // remainder correction
   assign rem = stsc_pkg::REM_BITS'(num) + stsc_pkg::REM_BITS'(qe_ff)
              - (stsc_pkg::REM_BITS'(qe_ff) << stsc_pkg::STICK_BITS);

   always_comb begin
      if (rem >= stsc_pkg::REM_BITS'(stsc_pkg::STICK_MAX)) begin
         quo = stsc_pkg::CFG_BITS'(qe_ff + 1'b1);
      end else begin
         quo = stsc_pkg::CFG_BITS'(qe_ff);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== design/stsc_ctrl.sv =====
// sequencer of the stick to servo conditioner
module stsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              kind,
   input  logic              tick_emit,
   input  logic              out_free,
   output logic              req_ready,
   output stsc_pkg::ctl_type ctl
);

   stsc_pkg::state_type state_ff, state_in;
   stsc_pkg::chan_type  chan_ff, chan_in;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         stsc_pkg::ST_IDLE: begin
            if (accept) begin
               chan_in = stsc_pkg::CH_FIRST;
               if (kind == stsc_pkg::KIND_PACKET) begin
                  state_in = stsc_pkg::ST_FMUL;
               end else if (tick_emit) begin
                  state_in = stsc_pkg::ST_WB;
               end
            end
         end
         stsc_pkg::ST_FMUL: state_in = stsc_pkg::ST_FADD;
         stsc_pkg::ST_FADD: begin
            if (chan_ff == stsc_pkg::CH_LAST) begin
               state_in = stsc_pkg::ST_MMUL;
               chan_in  = stsc_pkg::CH_FIRST;
            end else begin
               state_in = stsc_pkg::ST_FMUL;
               chan_in  = chan_ff + 1'b1;
            end
         end
         stsc_pkg::ST_MMUL: state_in = stsc_pkg::ST_MDIV;
         stsc_pkg::ST_MDIV: state_in = stsc_pkg::ST_MCOR;
         stsc_pkg::ST_MCOR: begin
            if (chan_ff == stsc_pkg::CH_LAST) begin
               state_in = stsc_pkg::ST_WB;
            end else begin
               state_in = stsc_pkg::ST_MMUL;
               chan_in  = chan_ff + 1'b1;
            end
         end
         stsc_pkg::ST_WB: begin
            if (out_free) begin
               state_in = stsc_pkg::ST_IDLE;
            end
         end
         default: state_in = stsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stsc_pkg::ST_IDLE;
         chan_ff  <= stsc_pkg::CH_FIRST;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   always_comb begin
      ctl.state = state_ff;
      ctl.chan  = chan_ff;
      req_ready = (state_ff == stsc_pkg::ST_IDLE);
      case (state_ff)
         stsc_pkg::ST_FMUL: ctl.op = stsc_pkg::ALU_MUL;
         stsc_pkg::ST_MMUL: ctl.op = stsc_pkg::ALU_MUL;
         stsc_pkg::ST_MDIV: ctl.op = stsc_pkg::ALU_DIV;
         default:           ctl.op = stsc_pkg::ALU_IDLE;
      endcase
   end

endmodule

// ===== design/stick_to_servo_conditioner.sv =====
// top level of the stick to servo conditioner
//
//   channel | direction | handshake           | carries
//   req_    | in        | req_valid/req_ready | kind and four stick readings
//   rsp_    | out       | rsp_valid/rsp_ready | throttle pulse, angles, flags
//   csr_    | in        | csr_wr_en           | register index and write data
//
// a control packet runs from the accept cycle through four filter steps
// (multiply, add) and four map steps (multiply, divide, correct) on the one
// multiplier and divide unit, then write-back; no new request is taken until
// idle. a tick reaches write-back only if it emits a failsafe result. reset is
// synchronous and clears control, filter, timer, hysteresis and valid state,
// not payload. a stalled result holds the block in write-back until taken.
module stick_to_servo_conditioner (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [stsc_pkg::IN_STICK_BITS-1:0]   req_stick_lx,
   input  logic [stsc_pkg::IN_STICK_BITS-1:0]   req_stick_ly,
   input  logic [stsc_pkg::IN_STICK_BITS-1:0]   req_stick_rx,
   input  logic [stsc_pkg::IN_STICK_BITS-1:0]   req_stick_ry,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [stsc_pkg::ESC_BITS-1:0]        rsp_esc_pulse_us,
   output logic [stsc_pkg::DEG_BITS-1:0]        rsp_aileron_deg,
   output logic [stsc_pkg::DEG_BITS-1:0]        rsp_elevator_deg,
   output logic [stsc_pkg::DEG_BITS-1:0]        rsp_rudder_deg,
   output logic                                 rsp_aileron_update,
   output logic                                 rsp_elevator_update,
   output logic                                 rsp_rudder_update,
   output logic                                 rsp_failsafe_active,
   input  logic                                 csr_wr_en,
   input  logic [stsc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [stsc_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

`include "stick_to_servo_conditioner_macros.svh"

   stsc_pkg::cfg_type cfg;
   stsc_pkg::ctl_type ctl;

   logic accept, tick_emit, out_free, load;

   logic [stsc_pkg::STICK_BITS-1:0] stick_ff [stsc_pkg::NUM_CH];
   logic [stsc_pkg::FILT_BITS-1:0]  filt_ff  [stsc_pkg::NUM_CH];
   logic [stsc_pkg::FILT_BITS-1:0]  filt_in;
   logic [stsc_pkg::TIME_BITS-1:0]  ms_ff, ms_in, ms_inc;
   logic                            fs_ff, fs_in;

   logic [stsc_pkg::ESC_BITS-1:0] esc_res_ff, esc_res_in;
   logic [stsc_pkg::DEG_BITS-1:0] ail_res_ff, ail_res_in;
   logic [stsc_pkg::DEG_BITS-1:0] ele_res_ff, ele_res_in;
   logic [stsc_pkg::DEG_BITS-1:0] rud_res_ff, rud_res_in;
   logic [stsc_pkg::DEG_BITS-1:0] last_ail_ff, last_ail_in;
   logic [stsc_pkg::DEG_BITS-1:0] last_ele_ff, last_ele_in;
   logic [stsc_pkg::DEG_BITS-1:0] last_rud_ff, last_rud_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [stsc_pkg::ESC_BITS-1:0] rsp_esc_ff, rsp_esc_in;
   logic [stsc_pkg::DEG_BITS-1:0] rsp_ail_ff, rsp_ail_in;
   logic [stsc_pkg::DEG_BITS-1:0] rsp_ele_ff, rsp_ele_in;
   logic [stsc_pkg::DEG_BITS-1:0] rsp_rud_ff, rsp_rud_in;
   logic                          rsp_ail_upd_ff, rsp_ail_upd_in;
   logic                          rsp_ele_upd_ff, rsp_ele_upd_in;
   logic                          rsp_rud_upd_ff, rsp_rud_upd_in;
   logic                          rsp_fs_ff, rsp_fs_in;

   logic [stsc_pkg::FILT_BITS-1:0]               filt_cur;
   logic [stsc_pkg::FILT_BITS-1:0]               stick_x;
   logic signed [stsc_pkg::DIFF_BITS-1:0]        diff;
   logic [stsc_pkg::ALPHA_BITS-1:0]              alpha_sat;
   logic signed [stsc_pkg::PROD_BITS-1:0]        alu_prod, prod_shift;
   logic [stsc_pkg::CFG_BITS-1:0]                alu_quo;
   logic signed [stsc_pkg::SUM_BITS-1:0]         fsum;
   logic [stsc_pkg::STICK_BITS-1:0]              v, clamp_v, map_v;
   logic [stsc_pkg::CMP_BITS-1:0]                v_w, c_w, snap_dist, snap_v;
   logic [stsc_pkg::CFG_BITS-1:0]                span;
   logic                                         thr_up;
   logic signed [stsc_pkg::MUL_A_BITS-1:0]       mul_a;
   logic signed [stsc_pkg::MUL_B_BITS-1:0]       mul_b;
   logic                                         ail_hit, ele_hit, rud_hit;

   function automatic logic hyst_hit(
      input logic [stsc_pkg::DEG_BITS-1:0]  s,
      input logic [stsc_pkg::DEG_BITS-1:0]  last,
      input logic [stsc_pkg::STEP_BITS-1:0] step
   );
      logic [stsc_pkg::DEG_BITS-1:0] d;
      d = (s > last) ? s - last : last - s;
      return (stsc_pkg::STEP_BITS'(d) >= step);
   endfunction

   stsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   stsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .tick_emit (tick_emit),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   stsc_alu u_alu (
      .clock (clock),
      .op    (ctl.op),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (alu_prod),
      .quo   (alu_quo)
   );

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = (ctl.state == stsc_pkg::ST_WB) && out_free;

   // millisecond counter
   assign ms_inc    = (ms_ff == stsc_pkg::TIME_SAT) ? ms_ff : ms_ff + 1'b1;
   assign tick_emit = (ms_inc > cfg.timeout);

   always_comb begin
      ms_in = ms_ff;
      fs_in = fs_ff;
      if (accept) begin
         fs_in = (req_kind == stsc_pkg::KIND_TICK);
         ms_in = (req_kind == stsc_pkg::KIND_TICK) ? ms_inc : '0;
      end
   end

   // filter step
   assign filt_cur   = filt_ff[ctl.chan];
   assign stick_x    = {stick_ff[ctl.chan], {stsc_pkg::FRAC_BITS{1'b0}}};
   assign diff       = stsc_pkg::DIFF_BITS'(stick_x) - stsc_pkg::DIFF_BITS'(filt_cur);
   assign alpha_sat  = (cfg.alpha > stsc_pkg::ALPHA_ONE) ? stsc_pkg::ALPHA_ONE : cfg.alpha;
   assign prod_shift = alu_prod >>> stsc_pkg::ALPHA_SHIFT;
   assign fsum       = stsc_pkg::SUM_BITS'(filt_cur) + stsc_pkg::SUM_BITS'(prod_shift);

   always_comb begin
      if (fsum[stsc_pkg::SUM_BITS-1]) begin
         filt_in = '0;
      end else if (fsum[stsc_pkg::SUM_BITS-2:0] > (stsc_pkg::SUM_BITS-1)'(stsc_pkg::FILT_MAX)) begin
         filt_in = stsc_pkg::FILT_MAX;
      end else begin
         filt_in = fsum[stsc_pkg::FILT_BITS-1:0];
      end
   end

   // deadband snap and clamp
   assign v         = filt_cur[stsc_pkg::FILT_BITS-1:stsc_pkg::FRAC_BITS];
   assign v_w       = stsc_pkg::CMP_BITS'(v);
   assign c_w       = stsc_pkg::CMP_BITS'(cfg.center);
   assign snap_dist = (v_w >= c_w) ? v_w - c_w : c_w - v_w;
   assign snap_v    = (snap_dist < stsc_pkg::CMP_BITS'(cfg.deadband)) ? c_w : v_w;
   assign clamp_v = (snap_v > stsc_pkg::CMP_BITS'(stsc_pkg::STICK_MAX)) ?
                    stsc_pkg::STICK_MAX : snap_v[stsc_pkg::STICK_BITS-1:0];
   assign map_v  = (ctl.chan == stsc_pkg::CH_LY) ? v : clamp_v;

   assign thr_up = (cfg.thr_max >= cfg.thr_min);
   assign span   = thr_up ? cfg.thr_max - cfg.thr_min : cfg.thr_min - cfg.thr_max;

   always_comb begin
      mul_a = diff;
      mul_b = stsc_pkg::MUL_B_BITS'(alpha_sat);
      if (ctl.state == stsc_pkg::ST_MMUL) begin
         mul_a = stsc_pkg::MUL_A_BITS'(map_v);
         mul_b = (ctl.chan == stsc_pkg::CH_LY) ? stsc_pkg::MUL_B_BITS'(span) :
                 stsc_pkg::MUL_B_BITS'(stsc_pkg::SERVO_MAX_DEG);
      end
   end

   // map results
   always_comb begin
      esc_res_in = esc_res_ff;
      ail_res_in = ail_res_ff;
      ele_res_in = ele_res_ff;
      rud_res_in = rud_res_ff;
      if (ctl.state == stsc_pkg::ST_MCOR) begin
         case (ctl.chan)
            stsc_pkg::CH_LX: rud_res_in = stsc_pkg::DEG_BITS'(alu_quo);
            stsc_pkg::CH_LY: esc_res_in = thr_up ?
                                          stsc_pkg::ESC_BITS'(cfg.thr_min + alu_quo) :
                                          stsc_pkg::ESC_BITS'(cfg.thr_min - alu_quo);
            stsc_pkg::CH_RX: ail_res_in = stsc_pkg::DEG_BITS'(alu_quo);
            stsc_pkg::CH_RY: ele_res_in = stsc_pkg::DEG_BITS'(alu_quo);
            default:         esc_res_in = esc_res_ff;
         endcase
      end
   end

   // write-back with hysteresis
   assign ail_hit = hyst_hit(ail_res_ff, last_ail_ff, cfg.step_min);
   assign ele_hit = hyst_hit(ele_res_ff, last_ele_ff, cfg.step_min);
   assign rud_hit = hyst_hit(rud_res_ff, last_rud_ff, cfg.step_min);

   always_comb begin
      last_ail_in    = last_ail_ff;
      last_ele_in    = last_ele_ff;
      last_rud_in    = last_rud_ff;
      rsp_esc_in     = rsp_esc_ff;
      rsp_ail_in     = rsp_ail_ff;
      rsp_ele_in     = rsp_ele_ff;
      rsp_rud_in     = rsp_rud_ff;
      rsp_ail_upd_in = rsp_ail_upd_ff;
      rsp_ele_upd_in = rsp_ele_upd_ff;
      rsp_rud_upd_in = rsp_rud_upd_ff;
      rsp_fs_in      = rsp_fs_ff;
      rsp_valid_in   = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_fs_in    = fs_ff;
         if (fs_ff) begin
            rsp_esc_in     = stsc_pkg::ESC_BITS'(cfg.thr_min);
            rsp_ail_in     = stsc_pkg::SERVO_MID_DEG;
            rsp_ele_in     = stsc_pkg::SERVO_MID_DEG;
            rsp_rud_in     = stsc_pkg::SERVO_MID_DEG;
            rsp_ail_upd_in = 1'b1;
            rsp_ele_upd_in = 1'b1;
            rsp_rud_upd_in = 1'b1;
         end else begin
            rsp_esc_in     = esc_res_ff;
            rsp_ail_in     = ail_res_ff;
            rsp_ele_in     = ele_res_ff;
            rsp_rud_in     = rud_res_ff;
            rsp_ail_upd_in = ail_hit;
            rsp_ele_upd_in = ele_hit;
            rsp_rud_upd_in = rud_hit;
            if (ail_hit) begin
               last_ail_in = ail_res_ff;
            end
            if (ele_hit) begin
               last_ele_in = ele_res_ff;
            end
            if (rud_hit) begin
               last_rud_in = rud_res_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stick_ff[stsc_pkg::CH_LX] <= stsc_pkg::STICK_BITS'(req_stick_lx);
         stick_ff[stsc_pkg::CH_LY] <= stsc_pkg::STICK_BITS'(req_stick_ly);
         stick_ff[stsc_pkg::CH_RX] <= stsc_pkg::STICK_BITS'(req_stick_rx);
         stick_ff[stsc_pkg::CH_RY] <= stsc_pkg::STICK_BITS'(req_stick_ry);
      end
      esc_res_ff     <= esc_res_in;
      ail_res_ff     <= ail_res_in;
      ele_res_ff     <= ele_res_in;
      rud_res_ff     <= rud_res_in;
      rsp_esc_ff     <= rsp_esc_in;
      rsp_ail_ff     <= rsp_ail_in;
      rsp_ele_ff     <= rsp_ele_in;
      rsp_rud_ff     <= rsp_rud_in;
      rsp_ail_upd_ff <= rsp_ail_upd_in;
      rsp_ele_upd_ff <= rsp_ele_upd_in;
      rsp_rud_upd_ff <= rsp_rud_upd_in;
      rsp_fs_ff      <= rsp_fs_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff[stsc_pkg::CH_LX] <= stsc_pkg::FILT_CENTER_RST;
         filt_ff[stsc_pkg::CH_LY] <= '0;
         filt_ff[stsc_pkg::CH_RX] <= stsc_pkg::FILT_CENTER_RST;
         filt_ff[stsc_pkg::CH_RY] <= stsc_pkg::FILT_CENTER_RST;
         ms_ff        <= '0;
         fs_ff        <= 1'b0;
         last_ail_ff  <= stsc_pkg::SERVO_MID_DEG;
         last_ele_ff  <= stsc_pkg::SERVO_MID_DEG;
         last_rud_ff  <= stsc_pkg::SERVO_MID_DEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.state == stsc_pkg::ST_FADD) begin
            filt_ff[ctl.chan] <= filt_in;
         end
         ms_ff        <= ms_in;
         fs_ff        <= fs_in;
         last_ail_ff  <= last_ail_in;
         last_ele_ff  <= last_ele_in;
         last_rud_ff  <= last_rud_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_esc_pulse_us    = rsp_esc_ff;
   assign rsp_aileron_deg     = rsp_ail_ff;
   assign rsp_elevator_deg    = rsp_ele_ff;
   assign rsp_rudder_deg      = rsp_rud_ff;
   assign rsp_aileron_update  = rsp_ail_upd_ff;
   assign rsp_elevator_update = rsp_ele_upd_ff;
   assign rsp_rudder_update   = rsp_rud_upd_ff;
   assign rsp_failsafe_active = rsp_fs_ff;

   `STSC_ASSERT_NEXT(a_packet_clears_ms, clock, reset, accept && req_kind == stsc_pkg::KIND_PACKET, ms_ff == '0)
   `STSC_ASSERT_SAME(a_rsp_from_wb, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(ctl.state == stsc_pkg::ST_WB))
   `STSC_ASSERT_SAME(a_failsafe_mid, clock, reset, rsp_valid_ff && rsp_fs_ff, rsp_ail_ff == stsc_pkg::SERVO_MID_DEG && rsp_ele_ff == stsc_pkg::SERVO_MID_DEG && rsp_rud_ff == stsc_pkg::SERVO_MID_DEG)
   `STSC_ASSERT_SAME(a_angle_range, clock, reset, rsp_valid_ff, rsp_ail_ff <= stsc_pkg::SERVO_MAX_DEG && rsp_ele_ff <= stsc_pkg::SERVO_MAX_DEG && rsp_rud_ff <= stsc_pkg::SERVO_MAX_DEG)

endmodule

// ===== tb/stick_to_servo_conditioner_tb.sv =====
`timescale 1ns / 100ps
// testbench for the stick to servo conditioner: directed and random traffic against a predictor
module stick_to_servo_conditioner_tb;
   import stsc_pkg::*;

   localparam csr_idx_type CSR_UNUSED = 3'd7;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 195;
   localparam int NUM_PHASES    = 8;
   localparam int BURST_TICKS   = 40;

   typedef struct packed {
      logic                     kind;
      logic [IN_STICK_BITS-1:0] lx;
      logic [IN_STICK_BITS-1:0] ly;
      logic [IN_STICK_BITS-1:0] rx;
      logic [IN_STICK_BITS-1:0] ry;
   } stick_frame_type;

   typedef struct packed {
      logic [ESC_BITS-1:0] esc_pulse_us;
      logic [DEG_BITS-1:0] aileron_deg;
      logic [DEG_BITS-1:0] elevator_deg;
      logic [DEG_BITS-1:0] rudder_deg;
      logic                aileron_update;
      logic                elevator_update;
      logic                rudder_update;
      logic                failsafe_active;
   } servo_cmd_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = KIND_PACKET;
   logic [IN_STICK_BITS-1:0] req_stick_lx = '0;
   logic [IN_STICK_BITS-1:0] req_stick_ly = '0;
   logic [IN_STICK_BITS-1:0] req_stick_rx = '0;
   logic [IN_STICK_BITS-1:0] req_stick_ry = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ESC_BITS-1:0]      rsp_esc_pulse_us;
   logic [DEG_BITS-1:0]      rsp_aileron_deg;
   logic [DEG_BITS-1:0]      rsp_elevator_deg;
   logic [DEG_BITS-1:0]      rsp_rudder_deg;
   logic                     rsp_aileron_update;
   logic                     rsp_elevator_update;
   logic                     rsp_rudder_update;
   logic                     rsp_failsafe_active;
   logic                     csr_wr_en = 1'b0;
   csr_idx_type              csr_index = CSR_STICK_CENTER;
   logic [CSR_DATA_BITS-1:0] csr_wr_data = '0;

   stick_frame_type frames_to_send [$];
   servo_cmd_type   cmds_expected [$];
   stick_frame_type cur_frame;

   cfg_type              regs;
   logic [FILT_BITS-1:0] filt_q [NUM_CH];
   logic [DEG_BITS-1:0]  last_deg [NUM_CH];
   logic [TIME_BITS-1:0] ms_idle;

   logic tx_idle_en = 1'b1;
   logic rx_idle_en = 1'b1;
   logic tick_burst = 1'b0;
   int   hold_reqs = 0;
   int   hold_seen = 0;
   int   tx_gap = 0;
   int   rx_stall = 0;
   int   rx_hold = 0;
   int   stuck_cycles = 0;
   int   mismatch_count = 0;

   stick_to_servo_conditioner u_top (.*);

   always #4 clock = ~clock;

   function automatic logic [FILT_BITS-1:0] ema_step(logic [FILT_BITS-1:0] f,
                                                    logic [IN_STICK_BITS-1:0] raw);
      longint a, x, p, r;
      a = (regs.alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(regs.alpha);
      x = longint'(raw & STICK_MAX) << FRAC_BITS;
      p = a * (x - longint'(f));
      r = longint'(f) + (p >>> ALPHA_SHIFT);
      if (r < 0) r = 0;
      if (r > longint'(FILT_MAX)) r = longint'(FILT_MAX);
      return FILT_BITS'(r);
   endfunction

   function automatic logic [DEG_BITS-1:0] stick_to_deg(logic [FILT_BITS-1:0] f);
      longint v, d;
      v = longint'(f >> FRAC_BITS);
      d = v - longint'(regs.center);
      if (d < 0) d = -d;
      if (d < longint'(regs.deadband)) v = longint'(regs.center);
      if (v > longint'(STICK_MAX)) v = longint'(STICK_MAX);
      return DEG_BITS'((v * longint'(SERVO_MAX_DEG)) / longint'(STICK_MAX));
   endfunction

   function automatic logic servo_moved(chan_type ch, logic [DEG_BITS-1:0] deg);
      logic [DEG_BITS-1:0] d;
      d = (deg > last_deg[ch]) ? deg - last_deg[ch] : last_deg[ch] - deg;
      if (d >= regs.step_min) begin
         last_deg[ch] = deg;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_servo_cmd(stick_frame_type fr);
      servo_cmd_type c;
      longint ly, lo, hi, esc;
      if (fr.kind == KIND_TICK) begin
         if (ms_idle != TIME_SAT) ms_idle = ms_idle + 1'b1;
         if (ms_idle > regs.timeout) begin
            c = '{regs.thr_min, SERVO_MID_DEG, SERVO_MID_DEG, SERVO_MID_DEG,
                  1'b1, 1'b1, 1'b1, 1'b1};
            cmds_expected.push_back(c);
         end
      end else begin
         ms_idle = '0;
         filt_q[CH_LX] = ema_step(filt_q[CH_LX], fr.lx);
         filt_q[CH_LY] = ema_step(filt_q[CH_LY], fr.ly);
         filt_q[CH_RX] = ema_step(filt_q[CH_RX], fr.rx);
         filt_q[CH_RY] = ema_step(filt_q[CH_RY], fr.ry);
         c.aileron_deg = stick_to_deg(filt_q[CH_RX]);
         c.elevator_deg = stick_to_deg(filt_q[CH_RY]);
         c.rudder_deg = stick_to_deg(filt_q[CH_LX]);
         ly = longint'(filt_q[CH_LY] >> FRAC_BITS);
         lo = longint'(regs.thr_min);
         hi = longint'(regs.thr_max);
         if (hi >= lo) esc = lo + (ly * (hi - lo)) / longint'(STICK_MAX);
         else esc = lo - (ly * (lo - hi)) / longint'(STICK_MAX);
         c.esc_pulse_us = ESC_BITS'(esc);
         c.aileron_update = servo_moved(CH_RX, c.aileron_deg);
         c.elevator_update = servo_moved(CH_RY, c.elevator_deg);
         c.rudder_update = servo_moved(CH_LX, c.rudder_deg);
         c.failsafe_active = 1'b0;
         cmds_expected.push_back(c);
      end
   endtask

   function automatic string cmd_text(servo_cmd_type c);
      return $sformatf("esc %0d ail %0d ele %0d rud %0d upd %b%b%b failsafe %b",
                       c.esc_pulse_us, c.aileron_deg, c.elevator_deg, c.rudder_deg,
                       c.aileron_update, c.elevator_update, c.rudder_update,
                       c.failsafe_active);
   endfunction

   task automatic check_servo_cmd();
      servo_cmd_type got, want;
      got = '{rsp_esc_pulse_us, rsp_aileron_deg, rsp_elevator_deg, rsp_rudder_deg,
              rsp_aileron_update, rsp_elevator_update, rsp_rudder_update,
              rsp_failsafe_active};
      if (cmds_expected.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("unexpected result: %s", cmd_text(got));
      end else begin
         want = cmds_expected.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch at %0t: expected %s", $realtime, cmd_text(want));
               $display("                  actual   %s", cmd_text(got));
            end
         end
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
      end else begin
         if (req_valid && req_ready) predict_servo_cmd(cur_frame);
         if (req_valid && !req_ready) begin
         end else if (tx_gap != 0) begin
            tx_gap <= tx_gap - 1;
            req_valid <= 1'b0;
         end else if (frames_to_send.size() != 0) begin
            cur_frame = frames_to_send.pop_front();
            req_kind <= cur_frame.kind;
            req_stick_lx <= cur_frame.lx;
            req_stick_ly <= cur_frame.ly;
            req_stick_rx <= cur_frame.rx;
            req_stick_ry <= cur_frame.ry;
            req_valid <= 1'b1;
            tx_gap <= (tx_idle_en && !tick_burst) ? int'($urandom_range(0, 6)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin : receiver
      int stall_draw;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall <= 0;
         rx_hold <= 0;
         hold_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_servo_cmd();
         if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            rx_hold <= $urandom_range(200, 400);
            rsp_ready <= 1'b0;
         end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            rsp_ready <= (rx_hold == 1);
         end else if (rsp_valid && rsp_ready) begin
            stall_draw = rx_idle_en ? int'($urandom_range(0, 6)) : 0;
            rx_stall <= stall_draw;
            rsp_ready <= (stall_draw == 0);
         end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            rsp_ready <= (rx_stall == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= IDLE_LIMIT) begin
         $display("** stick_to_servo_conditioner: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] junk, data;
      junk = CSR_DATA_BITS'($urandom);
      case (idx)
         CSR_STICK_CENTER: begin
            regs.center = value[11:0];
            data = {junk[15:12], value[11:0]};
         end
         CSR_DEADBAND: begin
            regs.deadband = value[11:0];
            data = {junk[15:12], value[11:0]};
         end
         CSR_ALPHA: begin
            regs.alpha = value[8:0];
            data = {junk[15:9], value[8:0]};
         end
         CSR_THR_MIN: begin
            regs.thr_min = value[11:0];
            data = {junk[15:12], value[11:0]};
         end
         CSR_THR_MAX: begin
            regs.thr_max = value[11:0];
            data = {junk[15:12], value[11:0]};
         end
         CSR_STEP_MIN: begin
            regs.step_min = value[7:0];
            data = {junk[15:8], value[7:0]};
         end
         CSR_TIMEOUT: begin
            regs.timeout = value;
            data = value;
         end
         default: data = junk;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_regs(cfg_type c);
      write_reg(CSR_STICK_CENTER, CSR_DATA_BITS'(c.center));
      write_reg(CSR_DEADBAND, CSR_DATA_BITS'(c.deadband));
      write_reg(CSR_ALPHA, CSR_DATA_BITS'(c.alpha));
      write_reg(CSR_THR_MIN, CSR_DATA_BITS'(c.thr_min));
      write_reg(CSR_THR_MAX, CSR_DATA_BITS'(c.thr_max));
      write_reg(CSR_STEP_MIN, CSR_DATA_BITS'(c.step_min));
      write_reg(CSR_TIMEOUT, CSR_DATA_BITS'(c.timeout));
      write_reg(CSR_UNUSED, '0);
   endtask

   function automatic cfg_type random_regs();
      cfg_type c;
      case ($urandom_range(0, 3))
         0: c.center = '0;
         1: c.center = '1;
         2: c.center = CFG_BITS'(2048);
         default: c.center = CFG_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: c.deadband = '0;
         1: c.deadband = '1;
         2: c.deadband = CFG_BITS'($urandom_range(0, 300));
         default: c.deadband = CFG_BITS'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: c.alpha = '0;
         1: c.alpha = ALPHA_ONE;
         2: c.alpha = ALPHA_BITS'($urandom_range(257, 511));
         default: c.alpha = ALPHA_BITS'($urandom_range(1, 255));
      endcase
      c.thr_min = ($urandom_range(0, 3) == 0) ? CFG_BITS'($urandom) :
                  CFG_BITS'($urandom_range(0, 2500));
      c.thr_max = ($urandom_range(0, 3) == 0) ? CFG_BITS'($urandom) :
                  CFG_BITS'($urandom_range(0, 2500));
      case ($urandom_range(0, 3))
         0: c.step_min = '0;
         1: c.step_min = STEP_BITS'(180);
         2: c.step_min = '1;
         default: c.step_min = STEP_BITS'($urandom_range(1, 6));
      endcase
      c.timeout = ($urandom_range(0, 2) == 0) ? '0 : TIME_BITS'($urandom_range(1, 24));
      return c;
   endfunction

   task automatic queue_packet(int lx, int ly, int rx, int ry);
      stick_frame_type fr;
      fr.kind = KIND_PACKET;
      fr.lx = IN_STICK_BITS'(lx);
      fr.ly = IN_STICK_BITS'(ly);
      fr.rx = IN_STICK_BITS'(rx);
      fr.ry = IN_STICK_BITS'(ry);
      frames_to_send.push_back(fr);
   endtask

   task automatic queue_ticks(int n);
      stick_frame_type fr;
      fr.kind = KIND_TICK;
      repeat (n) begin
         fr.lx = IN_STICK_BITS'($urandom);
         fr.ly = IN_STICK_BITS'($urandom);
         fr.rx = IN_STICK_BITS'($urandom);
         fr.ry = IN_STICK_BITS'($urandom);
         frames_to_send.push_back(fr);
      end
   endtask

   function automatic int clamp_stick(int v);
      if (v < 0) return 0;
      if (v > int'(STICK_MAX)) return int'(STICK_MAX);
      return v;
   endfunction

   function automatic int stick_target();
      int v;
      case ($urandom_range(0, 5))
         0: v = 0;
         1: v = int'(STICK_MAX);
         2: v = int'(regs.center);
         3: begin
            v = int'(regs.deadband) + int'($urandom_range(0, 2)) - 1;
            v = $urandom_range(0, 1) ? int'(regs.center) + v : int'(regs.center) - v;
         end
         default: v = int'($urandom_range(0, 4095));
      endcase
      return clamp_stick(v);
   endfunction

   function automatic int jittered(int t);
      if ($urandom_range(0, 1) == 0) return t;
      return clamp_stick(t + int'($urandom_range(0, 16)) - 8);
   endfunction

   // runs of packets toward a held stick position, and runs of ticks
   task automatic queue_random_traffic(int n);
      int count, run, lim;
      int aim [NUM_CH];
      count = 0;
      while (count < n) begin
         if ($urandom_range(0, 9) < 7) begin
            run = $urandom_range(1, 12);
            foreach (aim[i]) aim[i] = stick_target();
            repeat (run) begin
               queue_packet(jittered(aim[CH_LX]), jittered(aim[CH_LY]),
                            jittered(aim[CH_RX]), jittered(aim[CH_RY]));
            end
         end else begin
            lim = (regs.timeout < 40) ? int'(regs.timeout) + 3 : 8;
            run = $urandom_range(1, lim);
            queue_ticks(run);
         end
         count += run;
      end
   endtask

   // drain everything, then let the block settle
   task automatic wait_idle();
      do @(posedge clock);
      while (frames_to_send.size() != 0 || req_valid || cmds_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      cfg_type c;
      regs.center = CFG_BITS'(2048);
      regs.deadband = CFG_BITS'(45);
      regs.alpha = ALPHA_BITS'(90);
      regs.thr_min = CFG_BITS'(1100);
      regs.thr_max = CFG_BITS'(1940);
      regs.step_min = STEP_BITS'(2);
      regs.timeout = TIME_BITS'(300);
      filt_q[CH_LX] = FILT_CENTER_RST;
      filt_q[CH_LY] = '0;
      filt_q[CH_RX] = FILT_CENTER_RST;
      filt_q[CH_RY] = FILT_CENTER_RST;
      foreach (last_deg[i]) last_deg[i] = SERVO_MID_DEG;
      ms_idle = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: stick extremes, bit patterns, then timeout into failsafe
      queue_packet(0, 0, 0, 0);
      queue_packet(4095, 4095, 4095, 4095);
      queue_packet(4095, 4095, 4095, 4095);
      queue_packet('hAAA, 'h555, 'hAAA, 'h555);
      queue_packet('h555, 'hAAA, 'h555, 'hAAA);
      queue_packet(2048, 2048, 2048, 2048);
      queue_ticks(302);
      queue_packet(2048, 2048, 2048, 2048);
      wait_idle();

      // saturated alpha, zero step, inverted throttle, deadband edges
      c = regs;
      c.alpha = ALPHA_BITS'(300);
      c.step_min = '0;
      c.thr_min = CFG_BITS'(2500);
      c.thr_max = '0;
      load_regs(c);
      queue_packet(2092, 4095, 2003, 2004);
      queue_packet(2093, 0, 2004, 2003);
      queue_packet(0, 2048, 4095, 0);
      queue_packet(4095, 4095, 0, 4095);
      queue_packet(4095, 4095, 0, 4095);
      wait_idle();

      // largest timeout under a back-to-back tick burst, then the one below it with a packet
      c.timeout = TIME_SAT;
      load_regs(c);
      tick_burst <= 1'b1;
      queue_ticks(BURST_TICKS);
      wait_idle();
      c.timeout = TIME_SAT - 1'b1;
      load_regs(c);
      tick_burst <= 1'b0;
      queue_ticks(2);
      queue_packet(1000, 3000, 100, 4000);
      wait_idle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            c.center = '0;
            c.deadband = '0;
            c.alpha = ALPHA_ONE;
            c.thr_min = '0;
            c.thr_max = '1;
            c.step_min = '0;
            c.timeout = '0;
         end else if (ph == 1) begin
            c.center = '1;
            c.deadband = '1;
            c.alpha = '0;
            c.thr_min = '1;
            c.thr_max = '0;
            c.step_min = '1;
            c.timeout = TIME_BITS'(3);
         end else begin
            c = random_regs();
         end
         load_regs(c);
         tx_idle_en <= (ph != 4);
         rx_idle_en <= (ph != 4);
         queue_random_traffic(PHASE_ITEMS);
         if (ph == 2 || ph == 6) hold_reqs <= hold_reqs + 1;
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("** stick_to_servo_conditioner: PASSED **");
      end else begin
         $display("** stick_to_servo_conditioner: FAILED **");
      end
      $finish;
   end

endmodule
